@@ hdl/wtps_pkg.sv @@
package wtps_pkg;

  localparam int MAX_NODES = 4096;
  localparam int MAX_DEPTH = 16;
  localparam int ALPHABET  = 26;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int FREE_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int CUR_W   = $clog2(MAX_DEPTH);
  localparam int ENTRIES = MAX_NODES * ALPHABET;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int WGT_W   = 48;
  localparam int TOT_W   = 63;

  localparam logic [WGT_W-1:0] WEIGHT_MAX = {WGT_W{1'b1}};
  localparam logic [TOT_W-1:0] TOTAL_MAX  = {TOT_W{1'b1}};

  // Input operation codes.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_SEQ     = 2'd2;
  // The remaining code is accepted and ignored.
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Command kinds after classification.
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CLEAR   = 2'd1;
  localparam logic [1:0] KIND_PATTERN = 2'd2;
  localparam logic [1:0] KIND_SEQ     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  letter;
    logic [30:0] weight;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [TOT_W-1:0] total_weight;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        in_range;
    logic [4:0]  letter;
    logic [30:0] weight;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  // Flat table index of a node and letter.
  function automatic logic [IDX_W-1:0] table_index(logic [NODE_W-1:0] node,
                                                   logic [4:0] letter);
    table_index = IDX_W'(node) * IDX_W'(ALPHABET) + IDX_W'(letter);
  endfunction

endpackage

@@ hdl/wtps_front.sv @@
module wtps_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  wtps_pkg::item_t       item,
  output logic                  busy,
  input  wtps_pkg::back_status_t status,
  output wtps_pkg::queue_head_t head
);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  wtps_pkg::cmd_t       queue [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  wtps_pkg::cmd_t       cmd_in;
  logic                 accept;
  logic                 push;
  logic                 pop;

  // Classify the incoming item.
  always_comb begin
    cmd_in.letter   = item.letter;
    cmd_in.weight   = item.weight;
    cmd_in.last     = item.last;
    cmd_in.in_range = (item.letter < 5'(wtps_pkg::ALPHABET));
    unique case (item.op)
      wtps_pkg::OP_CLEAR:   cmd_in.kind = wtps_pkg::KIND_CLEAR;
      wtps_pkg::OP_PATTERN: cmd_in.kind = wtps_pkg::KIND_PATTERN;
      wtps_pkg::OP_SEQ:     cmd_in.kind = wtps_pkg::KIND_SEQ;
      default:              cmd_in.kind = wtps_pkg::KIND_NONE;
    endcase
  end

  assign busy   = (count == Q_CNT_W'(Q_DEPTH)) || status.clearing;
  assign accept = start && !busy;
  assign push   = accept && (cmd_in.kind != wtps_pkg::KIND_NONE);
  assign pop    = status.pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.cmd   = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

endmodule

@@ hdl/wtps_back.sv @@
module wtps_back (
  input  logic                   clk,
  input  logic                   rst,
  input  wtps_pkg::queue_head_t  head,
  output wtps_pkg::back_status_t status,
  output logic                   done,
  output wtps_pkg::result_t      result
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PWRITE = 3'd2;
  localparam logic [2:0] S_SEQ    = 3'd3;

  localparam int NW = wtps_pkg::NODE_W;
  localparam int IW = wtps_pkg::IDX_W;
  localparam int WW = wtps_pkg::WGT_W;
  localparam int TW = wtps_pkg::TOT_W;
  localparam int CW = wtps_pkg::CUR_W;

  logic [2:0] state;

  // Trie memories.
  logic [NW-1:0] child_mem  [wtps_pkg::ENTRIES];
  logic [WW-1:0] weight_mem [wtps_pkg::ENTRIES];
  logic [IW-1:0] mem_addr;
  logic          child_we;
  logic          weight_we;
  logic [NW-1:0] child_wdata;
  logic [WW-1:0] weight_wdata;
  logic [NW-1:0] child_rd;
  logic [WW-1:0] weight_rd;

  logic [IW-1:0] clr_addr;
  logic [wtps_pkg::FREE_W-1:0]  next_free;
  logic [NW-1:0]                ins_cursor;
  logic [wtps_pkg::DEPTH_W-1:0] ins_depth;
  logic                         ins_drop;
  logic [IW-1:0]                pat_idx;
  logic                         pat_last;
  logic [30:0]                  pat_weight;

  logic [NW-1:0] cur      [wtps_pkg::MAX_DEPTH];
  logic          cur_v    [wtps_pkg::MAX_DEPTH];
  logic [NW-1:0] nxt      [wtps_pkg::MAX_DEPTH];
  logic          nxt_v    [wtps_pkg::MAX_DEPTH];
  logic [CW:0]   issue_cnt;
  logic          stage_v;
  logic [CW-1:0] stage_d;
  logic          stage_ok;
  logic [4:0]    seq_letter;
  logic          seq_last;

  logic [TW-1:0] total;
  logic          ovf;
  logic [TW:0]   total_sum;
  logic [TW-1:0] total_next;
  logic [WW:0]   weight_sum;
  logic [IW-1:0] pat_idx_now;
  logic [IW-1:0] seq_idx;
  logic          take;
  logic          seq_end;
  logic          skip_end;

  assign take        = (state == S_IDLE) && head.valid;
  assign status.pop  = (state == S_IDLE);
  assign status.clearing = (state == S_CLEAR);
  assign pat_idx_now = wtps_pkg::table_index(ins_cursor, head.cmd.letter);
  assign seq_idx     = wtps_pkg::table_index(cur[issue_cnt[CW-1:0]], seq_letter);
  assign weight_sum  = {1'b0, weight_rd} + (WW+1)'(pat_weight);
  assign total_sum   = {1'b0, total} + (TW+1)'(weight_rd);

  // The deepest cursor of a sequence letter is in the data stage.
  assign seq_end  = (state == S_SEQ) && stage_v &&
                    (stage_d == CW'(wtps_pkg::MAX_DEPTH - 1));
  // A final sequence letter outside the alphabet ends the sequence at once.
  assign skip_end = take && (head.cmd.kind == wtps_pkg::KIND_SEQ) &&
                    !head.cmd.in_range && head.cmd.last;

  // Saturating total update from the entry in the data stage.
  always_comb begin
    total_next = total;
    if (stage_v && stage_ok) begin
      total_next = total_sum[TW] ? wtps_pkg::TOTAL_MAX : total_sum[TW-1:0];
    end
  end

  // Memory port selection.
  always_comb begin
    mem_addr     = seq_idx;
    child_we     = 1'b0;
    weight_we    = 1'b0;
    child_wdata  = '0;
    weight_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_addr  = clr_addr;
        child_we  = 1'b1;
        weight_we = 1'b1;
      end
      S_IDLE: begin
        mem_addr = pat_idx_now;
      end
      S_PWRITE: begin
        mem_addr = pat_idx;
        if (pat_last) begin
          weight_we    = 1'b1;
          weight_wdata = (weight_sum > (WW+1)'(wtps_pkg::WEIGHT_MAX)) ?
                         wtps_pkg::WEIGHT_MAX : weight_sum[WW-1:0];
        end else if (child_rd == '0 &&
                     next_free < wtps_pkg::FREE_W'(wtps_pkg::MAX_NODES)) begin
          child_we    = 1'b1;
          child_wdata = next_free[NW-1:0];
        end
      end
      S_SEQ: begin
        mem_addr = seq_idx;
      end
      default: begin
        mem_addr = seq_idx;
      end
    endcase
  end

  // Child link memory with registered read.
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[mem_addr] <= child_wdata;
    end else begin
      child_rd <= child_mem[mem_addr];
    end
  end

  // Weight memory with registered read.
  always_ff @(posedge clk) begin
    if (weight_we) begin
      weight_mem[mem_addr] <= weight_wdata;
    end else begin
      weight_rd <= weight_mem[mem_addr];
    end
  end

  // Result strobe and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (seq_end && seq_last) || skip_end;
      if (seq_end && seq_last) begin
        result.total_weight <= total_next;
        result.overflow     <= ovf;
      end else if (skip_end) begin
        result.total_weight <= total;
        result.overflow     <= ovf;
      end
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      next_free  <= wtps_pkg::FREE_W'(1);
      ins_cursor <= '0;
      ins_depth  <= '0;
      ins_drop   <= 1'b0;
      total      <= '0;
      ovf        <= 1'b0;
      stage_v    <= 1'b0;
      issue_cnt  <= '0;
      for (int i = 0; i < wtps_pkg::MAX_DEPTH; i++) begin
        cur_v[i] <= 1'b0;
        nxt_v[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          // One entry of both tables per cycle.
          if (clr_addr == IW'(wtps_pkg::ENTRIES - 1)) begin
            clr_addr <= '0;
            state    <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (take) begin
            unique case (head.cmd.kind)
              wtps_pkg::KIND_CLEAR: begin
                next_free  <= wtps_pkg::FREE_W'(1);
                ins_cursor <= '0;
                ins_depth  <= '0;
                ins_drop   <= 1'b0;
                total      <= '0;
                ovf        <= 1'b0;
                for (int i = 0; i < wtps_pkg::MAX_DEPTH; i++) cur_v[i] <= 1'b0;
                state <= S_CLEAR;
              end
              wtps_pkg::KIND_PATTERN: begin
                if (!ins_drop && head.cmd.in_range &&
                    ins_depth < wtps_pkg::DEPTH_W'(wtps_pkg::MAX_DEPTH)) begin
                  pat_idx    <= pat_idx_now;
                  pat_last   <= head.cmd.last;
                  pat_weight <= head.cmd.weight;
                  state      <= S_PWRITE;
                end else begin
                  // The rest of the pattern is dropped until its last letter.
                  ins_drop <= !head.cmd.last;
                  if (!ins_drop && head.cmd.in_range) ovf <= 1'b1;
                  if (head.cmd.last) begin
                    ins_cursor <= '0;
                    ins_depth  <= '0;
                  end
                end
              end
              wtps_pkg::KIND_SEQ: begin
                seq_letter <= head.cmd.letter;
                seq_last   <= head.cmd.last;
                if (head.cmd.in_range) begin
                  cur[0]    <= '0;
                  cur_v[0]  <= 1'b1;
                  issue_cnt <= '0;
                  stage_v   <= 1'b0;
                  for (int i = 0; i < wtps_pkg::MAX_DEPTH; i++) nxt_v[i] <= 1'b0;
                  state <= S_SEQ;
                end else begin
                  for (int i = 0; i < wtps_pkg::MAX_DEPTH; i++) cur_v[i] <= 1'b0;
                  if (head.cmd.last) begin
                    total <= '0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PWRITE: begin
          if (pat_last) begin
            ins_cursor <= '0;
            ins_depth  <= '0;
            ins_drop   <= 1'b0;
          end else if (child_rd != '0) begin
            ins_cursor <= child_rd;
            ins_depth  <= ins_depth + 1'b1;
          end else if (next_free < wtps_pkg::FREE_W'(wtps_pkg::MAX_NODES)) begin
            ins_cursor <= next_free[NW-1:0];
            ins_depth  <= ins_depth + 1'b1;
            next_free  <= next_free + 1'b1;
          end else begin
            ovf      <= 1'b1;
            ins_drop <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_SEQ: begin
          // Issue one cursor read per cycle; the previous one is in the data stage.
          if (issue_cnt <= (CW+1)'(wtps_pkg::MAX_DEPTH - 1)) begin
            stage_v   <= 1'b1;
            stage_d   <= issue_cnt[CW-1:0];
            stage_ok  <= cur_v[issue_cnt[CW-1:0]];
            issue_cnt <= issue_cnt + 1'b1;
          end else begin
            stage_v <= 1'b0;
          end
          // The total restarts after the final letter of a sequence.
          total <= (seq_end && seq_last) ? '0 : total_next;
          if (stage_v && stage_ok && child_rd != '0 &&
              stage_d != CW'(wtps_pkg::MAX_DEPTH - 1)) begin
            nxt[stage_d + 1'b1]   <= child_rd;
            nxt_v[stage_d + 1'b1] <= 1'b1;
          end
          if (seq_end) begin
            // Last cursor done: advance the cursor set.
            for (int i = 0; i < wtps_pkg::MAX_DEPTH; i++) begin
              cur[i]   <= nxt[i];
              cur_v[i] <= nxt_v[i] && !seq_last;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only follows a sequence step.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_SEQ || $past(state) == S_IDLE))
    else $error("result strobe outside a sequence step");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= wtps_pkg::FREE_W'(wtps_pkg::MAX_NODES))
    else $error("node allocator past table size");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    ins_depth <= wtps_pkg::DEPTH_W'(wtps_pkg::MAX_DEPTH))
    else $error("insert depth past maximum");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWRITE) |=> (state == S_IDLE))
    else $error("pattern write did not return to idle");

endmodule

@@ hdl/weighted_trie_pattern_sum.sv @@
// Weighted trie pattern sum.
// Input channel: an item (op, letter, weight, last) is taken at a rising
// clock edge where start is high and busy is low. A clear item empties the
// trie, the running total and the overflow flag; a pattern item loads one
// letter, and the pattern's last letter adds its weight; a sequence item
// streams one letter. Op code three is dropped at the input.
// Output channel: on a sequence letter marked last, done pulses for one
// cycle with the saturated total and the overflow flag. The receiver cannot
// stall; results must be taken in the cycle they appear.
// Items pass a four-entry queue to an executor with one read port per table.
// A sequence letter makes one table read per depth cursor, in a two-stage
// read pipeline (issue, then data); a pattern letter is a table read in idle
// and, unless it is dropped, a table write; the result is registered from
// the data stage of the deepest cursor. Reset and every clear item run a
// clearing pass over both tables, one entry a cycle; busy is held high during it.
module weighted_trie_pattern_sum (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wtps_pkg::item_t     item,
  output logic                busy,
  output logic                done,
  output wtps_pkg::result_t   result
);

  wtps_pkg::queue_head_t  head;
  wtps_pkg::back_status_t status;

  wtps_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .status (status),
    .head   (head)
  );

  wtps_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
